### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bfnc_pkg.sv
// ----------------------------------------------------------------------------
// bfnc_pkg
// types, widths and helpers of the negative cycle detector
// ----------------------------------------------------------------------------
package bfnc_pkg;

  localparam int VERTEX_W = 9;
  localparam int TIME_W   = 14;
  localparam int WEIGHT_W = 15;
  localparam int VCOUNT_W = 10;
  localparam int DIST_W   = 32;
  localparam int EDGE_W   = 2 * VERTEX_W + WEIGHT_W;
  localparam int DENTRY_W = DIST_W + 1;

  localparam logic signed [DIST_W-1:0] DIST_TOP = 32'sh7fff_ffff;
  localparam logic signed [DIST_W-1:0] DIST_BOT = 32'sh8000_0000;

  typedef struct packed {
    logic [VERTEX_W-1:0]        src;
    logic [VERTEX_W-1:0]        dst;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                     reached;
    logic signed [DIST_W-1:0] cost;
  } dist_entry_t;

  // distance plus weight, clamped to the signed 32-bit range
  function automatic logic signed [DIST_W-1:0] sat_add(
    input logic signed [DIST_W-1:0]   a,
    input logic signed [WEIGHT_W-1:0] b
  );
    logic signed [DIST_W:0] s;
    s = {a[DIST_W-1], a} + {{(DIST_W + 1 - WEIGHT_W){b[WEIGHT_W-1]}}, b};
    if (s[DIST_W] != s[DIST_W-1]) begin
      return s[DIST_W] ? DIST_BOT : DIST_TOP;
    end
    return s[DIST_W-1:0];
  endfunction

endpackage

### rtl/bfnc_ram.sv
// ----------------------------------------------------------------------------
// bfnc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module bfnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/bellman_ford_negative_cycle.sv
// ----------------------------------------------------------------------------
// bellman_ford_negative_cycle
// loads a weighted edge list and reports whether a negative cycle is
// reachable from vertex 0, using Bellman-Ford over an edge ram
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  in        in   in_valid_i / in_ready_o    from_vertex_i, to_vertex_i,
//                                            travel_time_i, negate_time_i,
//                                            last_edge_i
//  out       out  out_valid_o / out_ready_i  negative_cycle_o
//  cfg       in   vertex_count_we_i          vertex_count_i
//
//  edges load one per cycle while idle; the item with last_edge starts a run
//  run: clearing n distance ram entries, then n+1 passes over the stored
//  edges, each in the steps edge read, source read, destination read and
//  write back on the single distance ram read port, then the result
//  no items are taken during a run; the next graph may load while the result
//  waits for out_ready_i
//  reset clears control state only; ram contents are rebuilt each run
// ----------------------------------------------------------------------------
module bellman_ford_negative_cycle #(
  parameter int MAX_VERTICES = 512,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            vertex_count_we_i,
  input  logic [bfnc_pkg::VCOUNT_W-1:0]   vertex_count_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bfnc_pkg::VERTEX_W-1:0]   from_vertex_i,
  input  logic [bfnc_pkg::VERTEX_W-1:0]   to_vertex_i,
  input  logic [bfnc_pkg::TIME_W-1:0]     travel_time_i,
  input  logic                            negate_time_i,
  input  logic                            last_edge_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            negative_cycle_o
);

  import bfnc_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (VW > VERTEX_W) ? VW : VERTEX_W;
  localparam int KW = (NW > VERTEX_W) ? NW : VERTEX_W;
  localparam int LW = (NW > VCOUNT_W) ? NW : VCOUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_EDGE,
    S_SRC,
    S_DST,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [VCOUNT_W-1:0]  vertex_count_q;
  logic [CW-1:0]        edge_count_q, edge_count_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [NW-1:0]        pass_q, pass_d;
  logic [NW-1:0]        n_q, n_d;
  logic [VW-1:0]        clr_q, clr_d;
  logic signed [DIST_W-1:0] cand_q, cand_d;
  logic                 result_q, result_d;
  logic                 out_valid_q, out_valid_d;
  logic                 neg_cycle_q, neg_cycle_d;

  // edge store
  logic        in_acc;
  logic        e_we;
  edge_t       e_wdata;
  edge_t       e_rdata;
  logic [TIME_W:0] time_ext;

  // distance store
  logic          d_we;
  logic [VW-1:0] d_waddr, d_raddr;
  dist_entry_t   d_wdata, d_rdata;

  logic [LW-1:0] vc_ext;
  logic [LW-1:0] live_lw;
  logic [NW-1:0] live_n;
  logic [VW-1:0] src_idx, dst_idx;
  logic          src_ok, dst_ok;
  logic          edge_last, check_pass, advance, relax;

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign negative_cycle_o = neg_cycle_q;
  assign in_acc           = in_valid_i && in_ready_o;

  assign time_ext    = {1'b0, travel_time_i};
  assign e_we        = in_acc && (edge_count_q != CW'(MAX_EDGES));
  assign e_wdata.src = from_vertex_i;
  assign e_wdata.dst = to_vertex_i;
  assign e_wdata.weight = negate_time_i ? -$signed(time_ext) : $signed(time_ext);

  bfnc_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (edge_count_q[AW-1:0]),
    .wdata_i (e_wdata),
    .raddr_i (idx_d),
    .rdata_o (e_rdata)
  );

  bfnc_ram #(
    .WIDTH (DENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // vertex count in use: zero reads as one, clamped to the store size
  always_comb begin
    vc_ext = LW'(vertex_count_q);
    if (vertex_count_q == '0) begin
      live_lw = LW'(1);
    end else if (vc_ext > LW'(MAX_VERTICES)) begin
      live_lw = LW'(MAX_VERTICES);
    end else begin
      live_lw = vc_ext;
    end
    live_n = live_lw[NW-1:0];
  end

  always_comb begin
    logic [XW-1:0] src_x;
    logic [XW-1:0] dst_x;
    src_x   = XW'(e_rdata.src);
    dst_x   = XW'(e_rdata.dst);
    src_idx = src_x[VW-1:0];
    dst_idx = dst_x[VW-1:0];
    src_ok  = KW'(e_rdata.src) < KW'(n_q);
    dst_ok  = KW'(e_rdata.dst) < KW'(n_q);
  end

  assign edge_last  = (CW'(idx_q) == edge_count_q - CW'(1));
  assign check_pass = (pass_q == n_q);
  assign relax      = !d_rdata.reached || (cand_q < d_rdata.cost);

  always_comb begin
    state_d      = state_q;
    edge_count_d = edge_count_q;
    idx_d        = idx_q;
    pass_d       = pass_q;
    n_d          = n_q;
    clr_d        = clr_q;
    cand_d       = cand_q;
    result_d     = result_q;
    out_valid_d  = out_valid_q;
    neg_cycle_d  = neg_cycle_q;
    d_we         = 1'b0;
    d_waddr      = clr_q;
    d_wdata      = '0;
    d_raddr      = src_idx;
    advance      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (e_we) begin
            edge_count_d = edge_count_q + CW'(1);
          end
          if (last_edge_i) begin
            n_d     = live_n;
            clr_d   = '0;
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        // vertex 0 starts reached at distance 0, all others unreached
        d_we            = 1'b1;
        d_waddr         = clr_q;
        d_wdata.reached = (clr_q == '0);
        d_wdata.cost    = '0;
        if (NW'(clr_q) == n_q - NW'(1)) begin
          idx_d   = '0;
          pass_d  = '0;
          state_d = S_EDGE;
        end else begin
          clr_d = clr_q + VW'(1);
        end
      end
      S_EDGE: begin
        if (src_ok && dst_ok) begin
          d_raddr = src_idx;
          state_d = S_SRC;
        end else begin
          advance = 1'b1;
        end
      end
      S_SRC: begin
        if (d_rdata.reached) begin
          cand_d  = sat_add(d_rdata.cost, e_rdata.weight);
          d_raddr = dst_idx;
          state_d = S_DST;
        end else begin
          advance = 1'b1;
        end
      end
      S_DST: begin
        if (check_pass) begin
          if (relax) begin
            result_d = 1'b1;
            state_d  = S_DONE;
          end else begin
            advance = 1'b1;
          end
        end else begin
          if (relax) begin
            d_we            = 1'b1;
            d_waddr         = dst_idx;
            d_wdata.reached = 1'b1;
            d_wdata.cost    = cand_q;
          end
          advance = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          neg_cycle_d  = result_q;
          edge_count_d = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // step to the next stored edge, wrapping into the next pass or, after the check pass, ending the run
    if (advance) begin
      if (edge_last) begin
        if (check_pass) begin
          result_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          pass_d  = pass_q + NW'(1);
          idx_d   = '0;
          state_d = S_EDGE;
        end
      end else begin
        idx_d   = idx_q + AW'(1);
        state_d = S_EDGE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      vertex_count_q <= VCOUNT_W'(1);
      edge_count_q   <= '0;
      idx_q          <= '0;
      pass_q         <= '0;
      n_q            <= NW'(1);
      clr_q          <= '0;
      result_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      neg_cycle_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      if (vertex_count_we_i) begin
        vertex_count_q <= vertex_count_i;
      end
      edge_count_q   <= edge_count_d;
      idx_q          <= idx_d;
      pass_q         <= pass_d;
      n_q            <= n_d;
      clr_q          <= clr_d;
      result_q       <= result_d;
      out_valid_q    <= out_valid_d;
      neg_cycle_q    <= neg_cycle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  `ASSERT_IMPLIES(a_dist_write_state, d_we, (state_q == S_CLEAR || state_q == S_DST), "distance write outside clear or update")
  `ASSERT_NEXT(a_last_starts_run, (in_acc && last_edge_i), (state_q == S_CLEAR), "last edge did not start a run")
  `ASSERT_IMPLIES(a_idx_in_range, (state_q == S_EDGE || state_q == S_SRC || state_q == S_DST), (CW'(idx_q) < edge_count_q), "edge index beyond stored edges")
  `ASSERT_IMPLIES(a_check_no_write, (state_q == S_DST && check_pass), !d_we, "distance written during check pass")

endmodule

### verif/bellman_ford_negative_cycle_tb.sv
// ----------------------------------------------------------------------------
// bellman_ford_negative_cycle_tb
// loads edge lists into the detector and checks the negative cycle flag
// of every graph against a testbench bellman-ford predictor or a fixed verdict;
// a short table of hand-picked graphs, random graphs over many vertex
// counts with random stalls on both sides, then a full edge store and a
// graph whose distances saturate at the bottom of the 32-bit range
// ----------------------------------------------------------------------------
module bellman_ford_negative_cycle_tb;
  import bfnc_pkg::*;

  localparam int MAX_V = 512;
  localparam int MAX_E = 4096;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_AFTER = 1400;
  localparam int SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  typedef enum logic [1:0] {PREDICTED, KNOWN_CLEAR, KNOWN_CYCLE} verdict_src_e;

  typedef struct packed {
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
    logic [TIME_W-1:0]   tt;
    logic                neg;
  } edge_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]        src;
    logic [VERTEX_W-1:0]        dst;
    logic signed [WEIGHT_W-1:0] weight;
  } held_edge_t;

  typedef struct packed {
    logic         set_vc;
    logic [9:0]   vc;
    edge_item_t   item;
    logic         last;
    verdict_src_e verdict;
  } graph_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                vertex_count_we_i = 1'b0;
  logic [VCOUNT_W-1:0] vertex_count_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [VERTEX_W-1:0] from_vertex_i = '0;
  logic [VERTEX_W-1:0] to_vertex_i = '0;
  logic [TIME_W-1:0]   travel_time_i = '0;
  logic                negate_time_i = 1'b0;
  logic                last_edge_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                negative_cycle_o;

  bellman_ford_negative_cycle #(
    .MAX_VERTICES(MAX_V),
    .MAX_EDGES   (MAX_E)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vertex_count_we_i(vertex_count_we_i),
    .vertex_count_i   (vertex_count_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .from_vertex_i    (from_vertex_i),
    .to_vertex_i      (to_vertex_i),
    .travel_time_i    (travel_time_i),
    .negate_time_i    (negate_time_i),
    .last_edge_i      (last_edge_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .negative_cycle_o (negative_cycle_o)
  );

  // predictor copy of the edge store and the register
  held_edge_t  graph_edges [MAX_E];
  int unsigned graph_len = 0;
  logic [9:0]  vc_shadow = 10'd1;
  bit          pending_verdicts [$];

  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned edges_loaded = 0;
  int unsigned graphs_run = 0;
  int unsigned cycles_found = 0;
  int unsigned vc_writes = 0;
  graph_row_t  graph_rows [$];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int live_count(input logic [9:0] vc);
    if (vc == 0) return 1;
    if (vc > MAX_V) return MAX_V;
    return int'(vc);
  endfunction

  function automatic logic signed [DIST_W-1:0] clamp_sum(
    input logic signed [DIST_W-1:0]   d,
    input logic signed [WEIGHT_W-1:0] w
  );
    longint s;
    s = longint'(d) + longint'(w);
    if (s > longint'(DIST_TOP)) return DIST_TOP;
    if (s < longint'(DIST_BOT)) return DIST_BOT;
    return s[DIST_W-1:0];
  endfunction

  // n relaxation passes in load order, then one pass looking for any relaxation
  function automatic bit cycle_reachable();
    int n;
    held_edge_t e;
    logic signed [DIST_W-1:0] cost_tab [MAX_V];
    bit seen [MAX_V];
    logic signed [DIST_W-1:0] cand;
    n = live_count(vc_shadow);
    for (int v = 0; v < MAX_V; v++) begin
      cost_tab[v] = '0;
      seen[v] = 1'b0;
    end
    seen[0] = 1'b1;
    for (int pass = 0; pass <= n; pass++) begin
      for (int i = 0; i < graph_len; i++) begin
        e = graph_edges[i];
        if (e.src >= n || e.dst >= n || !seen[e.src]) continue;
        cand = clamp_sum(cost_tab[e.src], e.weight);
        if (!seen[e.dst] || cand < cost_tab[e.dst]) begin
          if (pass == n) return 1'b1;
          cost_tab[e.dst] = cand;
          seen[e.dst] = 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what, input bit got, input bit want);
    $display("%0t %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic load_edge(input edge_item_t e, input bit last, input verdict_src_e src);
    bit verdict;
    logic signed [WEIGHT_W-1:0] wt;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    from_vertex_i <= e.src;
    to_vertex_i   <= e.dst;
    travel_time_i <= e.tt;
    negate_time_i <= e.neg;
    last_edge_i   <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    edges_loaded++;
    // a full store drops the item, a last flag still starts the run
    if (graph_len < MAX_E) begin
      wt = e.neg ? -$signed({1'b0, e.tt}) : $signed({1'b0, e.tt});
      graph_edges[graph_len] = '{src: e.src, dst: e.dst, weight: wt};
      graph_len++;
    end
    if (last) begin
      verdict = cycle_reachable();
      case (src)
        KNOWN_CLEAR: pending_verdicts = {pending_verdicts, 1'b0};
        KNOWN_CYCLE: pending_verdicts = {pending_verdicts, 1'b1};
        default:     pending_verdicts = {pending_verdicts, verdict};
      endcase
      if (verdict) cycles_found++;
      graphs_run++;
      graph_len = 0;
    end
  endtask

  // only while no run is going: all verdicts in, then a short settle
  task automatic set_vertex_count(input logic [9:0] v);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    vertex_count_we_i <= 1'b1;
    vertex_count_i    <= v;
    @(posedge clk_i);
    vertex_count_we_i <= 1'b0;
    vc_shadow = v;
    vc_writes++;
  endtask

  function automatic logic [VERTEX_W-1:0] pick_vertex(input int n_live);
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 92) return VERTEX_W'($urandom_range(0, n_live - 1));
    return VERTEX_W'($urandom_range(0, 511));
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return TIME_W'($urandom_range(0, 20));
    if (r < 80) return TIME_W'($urandom_range(0, 200));
    if (r < 92) return TIME_W'($urandom_range(0, 10000));
    if (r < 96) return $urandom_range(0, 1) ? 14'd10000 : 14'd0;
    return TIME_W'($urandom_range(10001, 16383));
  endfunction

  function automatic edge_item_t random_edge(input int n_live);
    edge_item_t e;
    e.src = pick_vertex(n_live);
    e.dst = pick_vertex(n_live);
    e.tt  = pick_time();
    e.neg = $urandom_range(0, 99) < 40;
    return e;
  endfunction

  function automatic edge_item_t weighted_edge(input int s, input int d, input int w);
    edge_item_t e;
    e.src = VERTEX_W'(s);
    e.dst = VERTEX_W'(d);
    e.tt  = TIME_W'((w < 0) ? -w : w);
    e.neg = w < 0;
    return e;
  endfunction

  // half the graphs carry a closed walk through vertex 0 with a total
  // weight near zero, so both verdicts come up often
  task automatic send_graph(input int n_live, input int max_len, output int placed);
    edge_item_t batch [$];
    edge_item_t tmp;
    int count, walk_len, total, target, w, prev, nxt, j;
    count = $urandom_range(1, max_len);
    if ($urandom_range(0, 1)) begin
      walk_len = $urandom_range(1, (max_len < 4) ? max_len : 4);
      if (count < walk_len) count = walk_len;
      target = $urandom_range(0, 10) - 5;
      total = 0;
      prev = 0;
      for (int k = 0; k < walk_len; k++) begin
        nxt = (k == walk_len - 1) ? 0 : $urandom_range(0, n_live - 1);
        w = (k == walk_len - 1) ? target - total : $urandom_range(0, 40) - 20;
        total += w;
        batch = {batch, weighted_edge(prev, nxt, w)};
        prev = nxt;
      end
    end
    while (batch.size() < count) batch = {batch, random_edge(n_live)};
    for (int k = batch.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = batch[k];
      batch[k] = batch[j];
      batch[j] = tmp;
    end
    for (int k = 0; k < batch.size(); k++) begin
      load_edge(batch[k], k == batch.size() - 1, PREDICTED);
    end
    placed = batch.size();
  endtask

  task automatic add_row(input logic set_vc, input logic [9:0] vc, input int s, input int d,
                         input int tt, input logic neg, input logic last,
                         input verdict_src_e verdict);
    graph_row_t r;
    r.set_vc = set_vc;
    r.vc = vc;
    r.item = '{src: VERTEX_W'(s), dst: VERTEX_W'(d), tt: TIME_W'(tt), neg: neg};
    r.last = last;
    r.verdict = verdict;
    graph_rows = {graph_rows, r};
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
               pending_verdicts.size());
      $display("bellman_ford_negative_cycle: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("verdict with no graph pending", negative_cycle_o, 1'b0);
      end else if (negative_cycle_o !== pending_verdicts[0]) begin
        note_mismatch("negative_cycle", negative_cycle_o, pending_verdicts.pop_front());
      end else begin
        void'(pending_verdicts.pop_front());
      end
    end
  end

  initial begin
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  end

  initial begin
    int rand_items, n_live, quota, placed, count, kind;
    bit big;
    logic [9:0] vc;
    edge_item_t e;

    //      set  vc     src  dst  time   neg   last  verdict
    add_row(0, 10'd0,    0,   0,      0, 1'b0, 1'b1, KNOWN_CLEAR);  // reset count of 1
    add_row(0, 10'd0,    0,   0,      5, 1'b1, 1'b1, KNOWN_CYCLE);
    add_row(1, 10'd0,    0,   0,      1, 1'b1, 1'b1, KNOWN_CYCLE);  // 0 acts as 1
    add_row(1, 10'd2,    0,   1,  10000, 1'b0, 1'b1, KNOWN_CLEAR);
    add_row(0, 10'd0,    0,   1,      3, 1'b0, 1'b0, PREDICTED);
    add_row(0, 10'd0,    1,   0,      3, 1'b1, 1'b1, KNOWN_CLEAR);  // zero-sum loop
    add_row(0, 10'd0,    0,   1,      4, 1'b0, 1'b0, PREDICTED);
    add_row(0, 10'd0,    1,   0,      5, 1'b1, 1'b1, KNOWN_CYCLE);
    add_row(0, 10'd0,    1,   1,      7, 1'b1, 1'b1, KNOWN_CLEAR);  // unreached source
    add_row(0, 10'd0,    0,   2,      1, 1'b1, 1'b0, PREDICTED);
    add_row(0, 10'd0,    2,   0,      1, 1'b1, 1'b0, PREDICTED);
    add_row(0, 10'd0,  511, 511,  16383, 1'b1, 1'b1, KNOWN_CLEAR);  // vertices past count
    add_row(1, 10'd1023, 0, 511,  16383, 1'b0, 1'b0, PREDICTED);
    add_row(0, 10'd0,  511,   0,  16383, 1'b1, 1'b1, KNOWN_CLEAR);
    add_row(1, 10'd512, 511,  0,      0, 1'b0, 1'b0, PREDICTED);
    add_row(0, 10'd0,    0, 511,      1, 1'b1, 1'b1, KNOWN_CYCLE);
    add_row(1, 10'd1,    0,   2,      2, 1'b1, 1'b0, PREDICTED);
    add_row(1, 10'd3,    2,   0,      1, 1'b0, 1'b1, PREDICTED);    // count changed mid-load
    add_row(1, 10'd4,    2,   3,      1, 1'b1, 1'b0, PREDICTED);
    add_row(0, 10'd0,    0,   2,      6, 1'b0, 1'b0, PREDICTED);
    add_row(0, 10'd0,    3,   2,      0, 1'b0, 1'b1, PREDICTED);
    add_row(0, 10'd0,    0,   0,  16383, 1'b1, 1'b1, PREDICTED);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (graph_rows[i]) begin
      if (graph_rows[i].set_vc) set_vertex_count(graph_rows[i].vc);
      load_edge(graph_rows[i].item, graph_rows[i].last, graph_rows[i].verdict);
    end

    // random graphs; big vertex counts get few, short graphs
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      big = 1'b0;
      if (kind == 0) begin
        big = 1'b1;
        case ($urandom_range(0, 2))
          0:       vc = 10'd512;
          1:       vc = 10'd1023;
          default: vc = VCOUNT_W'($urandom_range(513, 1022));
        endcase
      end else if (kind == 1) begin
        vc = 10'd0;
      end else if (kind < 14) begin
        vc = VCOUNT_W'($urandom_range(1, 8));
      end else begin
        vc = VCOUNT_W'($urandom_range(9, 40));
      end
      set_vertex_count(vc);
      n_live = live_count(vc);
      quota = big ? $urandom_range(6, 14) : $urandom_range(25, 60);
      count = 0;
      while (count < quota) begin
        send_graph(n_live, big ? 4 : 10, placed);
        count += placed;
      end
      rand_items += count;
      if (rand_items >= CALM_AFTER) calm = 1'b1;
      // sometimes leave a graph half loaded across the next register write
      if (!calm && $urandom_range(0, 5) == 0) begin
        count = $urandom_range(1, 3);
        repeat (count) load_edge(random_edge(n_live), 1'b0, PREDICTED);
        rand_items += count;
      end
    end

    // full store: the trailing negative self loops are dropped
    set_vertex_count(10'd1);
    for (int k = 0; k < MAX_E + 4; k++) begin
      if (k < MAX_E) e = weighted_edge(0, (k % 64 == 5) ? 1 : 0, $urandom_range(0, 50));
      else e = weighted_edge(0, 0, -7);
      load_edge(e, k == MAX_E + 3, PREDICTED);
    end

    // enough negative self loops to pin vertex 0 at the bottom of the range
    set_vertex_count(10'd1023);
    for (int k = 0; k < 260; k++) begin
      load_edge(weighted_edge(0, 0, -16383), k == 259, PREDICTED);
    end

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("%0d edges in %0d graphs, %0d of them with a reachable negative cycle",
             edges_loaded, graphs_run, cycles_found);
    $display("%0d vertex count writes from 0 to 1023, a full edge store and saturated distances",
             vc_writes);
    if (mismatches == 0) begin
      $display("bellman_ford_negative_cycle: match");
    end else begin
      $display("bellman_ford_negative_cycle: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bfnc_pkg.sv
rtl/bfnc_ram.sv
rtl/bellman_ford_negative_cycle.sv
verif/bellman_ford_negative_cycle_tb.sv
